@@ sv/cpio_newc_archive_walker_defines.svh @@
// ----------------------------------------------------------------------------
// cpio_newc_archive_walker_defines.svh
// Assertion macros used by the checker of the archive walker.
// ----------------------------------------------------------------------------
`ifndef CPIO_NEWC_ARCHIVE_WALKER_DEFINES_SVH
`define CPIO_NEWC_ARCHIVE_WALKER_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while arst_n is low.
`define CNAW_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("cpio walker check failed");

// Next-cycle implication, sampled on clk and disabled while arst_n is low.
`define CNAW_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("cpio walker check failed");

`endif

@@ sv/cnaw_pkg.sv @@
// ----------------------------------------------------------------------------
// cnaw_pkg
// Codes, header layout constants and character tables of the newc walker.
// ----------------------------------------------------------------------------
package cnaw_pkg;

	// Byte roles; the walker's region register uses the first five.
	localparam logic [2:0] ROLE_HDR  = 3'd0;
	localparam logic [2:0] ROLE_NAME = 3'd1;
	localparam logic [2:0] ROLE_NPAD = 3'd2;
	localparam logic [2:0] ROLE_DATA = 3'd3;
	localparam logic [2:0] ROLE_DPAD = 3'd4;
	localparam logic [2:0] ROLE_IGN  = 3'd5;

	// Walk status codes.
	localparam logic [2:0] STAT_WALKING = 3'd0;
	localparam logic [2:0] STAT_BAD_MAGIC = 3'd1;
	localparam logic [2:0] STAT_TRAILER = 3'd2;
	localparam logic [2:0] STAT_CLEAN_END = 3'd3;
	localparam logic [2:0] STAT_MID_ENTRY = 3'd4;

	// Header layout, in byte offsets from the start of the entry.
	localparam logic [31:0] HDR_LEN     = 32'd110;
	localparam logic [31:0] MAGIC_LEN   = 32'd6;
	localparam logic [31:0] FSIZE_FIRST = 32'd54;
	localparam logic [31:0] FSIZE_LAST  = 32'd61;
	localparam logic [31:0] NSIZE_FIRST = 32'd94;
	localparam logic [31:0] NSIZE_LAST  = 32'd101;
	localparam logic [31:0] TRAILER_LEN = 32'd10;

	typedef logic [2:0] role_t;
	typedef logic [2:0] status_t;

	// Value of one ASCII hex digit; anything else counts as zero.
	function automatic logic [3:0] hex_nibble(input logic [7:0] c);
		logic [3:0] n;
		n = 4'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			n = 4'(c - 8'h30);
		end else if (c >= 8'h61 && c <= 8'h66) begin
			n = 4'(c - 8'h57);
		end else if (c >= 8'h41 && c <= 8'h46) begin
			n = 4'(c - 8'h37);
		end
		return n;
	endfunction

	// The magic string "070701".
	function automatic logic [7:0] magic_char(input logic [2:0] idx);
		logic [7:0] c;
		case (idx)
			3'd0: c = 8'h30;
			3'd1: c = 8'h37;
			3'd2: c = 8'h30;
			3'd3: c = 8'h37;
			3'd4: c = 8'h30;
			3'd5: c = 8'h31;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	// The end-of-archive name "TRAILER!!!".
	function automatic logic [7:0] trailer_char(input logic [3:0] idx);
		logic [7:0] c;
		case (idx)
			4'd0: c = 8'h54;
			4'd1: c = 8'h52;
			4'd2: c = 8'h41;
			4'd3: c = 8'h49;
			4'd4: c = 8'h4C;
			4'd5: c = 8'h45;
			4'd6: c = 8'h52;
			4'd7: c = 8'h21;
			4'd8: c = 8'h21;
			4'd9: c = 8'h21;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

@@ sv/cpio_newc_archive_walker.sv @@
// ----------------------------------------------------------------------------
// cpio_newc_archive_walker
// Byte-serial walker that labels every byte of a newc cpio archive image.
// ----------------------------------------------------------------------------
// The walker takes one archive byte per clock cycle on the item channel and
// returns one result word per byte on the result channel, in the cycle after the
// byte is accepted. All per-byte work (offset count, magic and trailer checks,
// hex decode of the size fields, region advance) sits in the logic between the
// walk state registers and a single result register, so a byte can be taken
// in every cycle; the result register is the only stage, and the item channel
// stalls only while that register holds a word the consumer has not taken.
// The walk stops for good on a bad magic, a TRAILER!!! name or the byte marked
// last; later bytes are reported as ignored until reset restarts the walk.
module cpio_newc_archive_walker
	import cnaw_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// Archive byte channel.
	input  logic        item_valid,
	output logic        item_ready,
	input  logic [7:0]  image_byte,
	input  logic        image_last,
	// Result channel.
	output logic        result_valid,
	input  logic        result_ready,
	output logic [2:0]  byte_role,
	output logic        entry_start,
	output logic        entry_done,
	output logic [31:0] name_length,
	output logic [31:0] file_length,
	output logic [2:0]  walk_status
);

	// Walk state.
	role_t       region_q;
	logic [31:0] offset_q;
	logic [31:0] hex_acc_q;
	logic [31:0] name_len_q;
	logic [31:0] file_len_q;
	logic        trl_match_q;
	status_t     status_q;

	// Next-state values for one accepted word.
	role_t       region_d;
	logic [31:0] offset_d;
	logic [31:0] hex_acc_d;
	logic [31:0] name_len_d;
	logic [31:0] file_len_d;
	logic        trl_match_d;
	status_t     status_d;

	role_t       role_c;
	logic        start_c;
	logic        done_c;

	// Region lengths and advance helpers.
	logic [31:0] offset_inc;
	logic [31:0] cur_len;
	logic [1:0]  npad_len;
	logic [1:0]  dpad_len;
	role_t       next_region;
	logic        next_wraps;
	logic        in_size_field;

	logic        out_valid_q;
	logic        accept;

	// The result register frees up in the same cycle it is read, so the walker
	// keeps streaming at full rate as long as the consumer keeps up.
	assign item_ready = !out_valid_q || result_ready;
	assign accept     = item_valid && item_ready;

	// The name pad aligns the 110-byte header plus the name to four bytes; the
	// data pad aligns the file data. Only the low two bits of a size matter.
	assign npad_len = 2'd2 - name_len_q[1:0];
	assign dpad_len = 2'd0 - file_len_q[1:0];

	always_comb begin
		case (region_q)
			ROLE_HDR:  cur_len = HDR_LEN;
			ROLE_NAME: cur_len = name_len_q;
			ROLE_NPAD: cur_len = {30'd0, npad_len};
			ROLE_DATA: cur_len = file_len_q;
			default:   cur_len = {30'd0, dpad_len};
		endcase
	end

	// First non-empty region after the current one; when every later region
	// is empty the entry is complete and the next byte opens a new header.
	always_comb begin
		next_wraps = 1'b0;
		if (region_q < ROLE_NAME && name_len_q != 32'd0) begin
			next_region = ROLE_NAME;
		end else if (region_q < ROLE_NPAD && npad_len != 2'd0) begin
			next_region = ROLE_NPAD;
		end else if (region_q < ROLE_DATA && file_len_q != 32'd0) begin
			next_region = ROLE_DATA;
		end else if (region_q < ROLE_DPAD && dpad_len != 2'd0) begin
			next_region = ROLE_DPAD;
		end else begin
			next_region = ROLE_HDR;
			next_wraps  = 1'b1;
		end
	end

	assign offset_inc    = offset_q + 32'd1;
	assign in_size_field = (offset_q >= FSIZE_FIRST && offset_q <= FSIZE_LAST) ||
		(offset_q >= NSIZE_FIRST && offset_q <= NSIZE_LAST);

	always_comb begin
		region_d    = region_q;
		offset_d    = offset_q;
		hex_acc_d   = hex_acc_q;
		name_len_d  = name_len_q;
		file_len_d  = file_len_q;
		trl_match_d = trl_match_q;
		status_d    = status_q;
		role_c      = ROLE_IGN;
		start_c     = 1'b0;
		done_c      = 1'b0;

		if (status_q == STAT_WALKING) begin
			role_c = region_q;
			if (region_q == ROLE_HDR) begin
				if (offset_q == 32'd0) begin
					start_c     = 1'b1;
					trl_match_d = 1'b1;
				end
				if (offset_q < MAGIC_LEN && image_byte != magic_char(offset_q[2:0])) begin
					status_d = STAT_BAD_MAGIC;
				end
				// Size fields are eight hex digits, most significant first.
				if (in_size_field) begin
					if (offset_q == FSIZE_FIRST || offset_q == NSIZE_FIRST) begin
						hex_acc_d = {28'd0, hex_nibble(image_byte)};
					end else begin
						hex_acc_d = {hex_acc_q[27:0], hex_nibble(image_byte)};
					end
					if (offset_q == FSIZE_LAST) begin
						file_len_d = hex_acc_d;
					end
					if (offset_q == NSIZE_LAST) begin
						name_len_d = hex_acc_d;
					end
				end
			end else if (region_q == ROLE_NAME && offset_q < TRAILER_LEN) begin
				if (image_byte != trailer_char(offset_q[3:0])) begin
					trl_match_d = 1'b0;
				end
				// A name shorter than ten bytes can never be the trailer.
				if (offset_q == TRAILER_LEN - 32'd1 && trl_match_d &&
					name_len_q >= TRAILER_LEN) begin
					status_d = STAT_TRAILER;
				end
			end

			if (status_d == STAT_WALKING) begin
				if (offset_inc >= cur_len) begin
					region_d = next_region;
					offset_d = 32'd0;
					done_c   = next_wraps;
				end else begin
					offset_d = offset_inc;
				end
				if (image_last) begin
					if (region_d == ROLE_HDR && offset_d == 32'd0) begin
						status_d = STAT_CLEAN_END;
					end else begin
						status_d = STAT_MID_ENTRY;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			region_q    <= ROLE_HDR;
			offset_q    <= 32'd0;
			hex_acc_q   <= 32'd0;
			name_len_q  <= 32'd0;
			file_len_q  <= 32'd0;
			trl_match_q <= 1'b1;
			status_q    <= STAT_WALKING;
		end else if (accept) begin
			region_q    <= region_d;
			offset_q    <= offset_d;
			hex_acc_q   <= hex_acc_d;
			name_len_q  <= name_len_d;
			file_len_q  <= file_len_d;
			trl_match_q <= trl_match_d;
			status_q    <= status_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload; it only loads on an accepted byte, so a stalled word holds.
	logic [2:0]  role_q;
	logic        start_q;
	logic        done_q;
	logic [31:0] name_out_q;
	logic [31:0] file_out_q;
	logic [2:0]  status_out_q;

	always_ff @(posedge clk) begin
		if (accept) begin
			role_q       <= role_c;
			start_q      <= start_c;
			done_q       <= done_c;
			name_out_q   <= name_len_d;
			file_out_q   <= file_len_d;
			status_out_q <= status_d;
		end
	end

	assign result_valid = out_valid_q;
	assign byte_role    = role_q;
	assign entry_start  = start_q;
	assign entry_done   = done_q;
	assign name_length  = name_out_q;
	assign file_length  = file_out_q;
	assign walk_status  = status_out_q;

endmodule

@@ sv/cnaw_checker.sv @@
// ----------------------------------------------------------------------------
// cnaw_checker
// Port-level checks of the archive walker, attached by a bind statement.
// ----------------------------------------------------------------------------
`include "cpio_newc_archive_walker_defines.svh"

module cnaw_checker
	import cnaw_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        item_valid,
	input logic        item_ready,
	input logic [7:0]  image_byte,
	input logic        image_last,
	input logic        result_valid,
	input logic        result_ready,
	input logic [2:0]  byte_role,
	input logic        entry_start,
	input logic        entry_done,
	input logic [31:0] name_length,
	input logic [31:0] file_length,
	input logic [2:0]  walk_status
);

	logic        in_stall;
	logic        out_stall;
	logic [8:0]  in_word;
	logic [71:0] out_word;
	logic        start_word;
	logic        ignored_word;
	logic        done_word;
	logic        quiet_flags;
	logic        walk_open;

	assign in_stall     = item_valid && !item_ready;
	assign out_stall    = result_valid && !result_ready;
	assign in_word      = {image_byte, image_last};
	assign out_word     = {byte_role, entry_start, entry_done, name_length, file_length,
		walk_status};
	assign start_word   = result_valid && entry_start;
	assign ignored_word = result_valid && byte_role == ROLE_IGN;
	assign done_word    = result_valid && entry_done;
	assign quiet_flags  = !entry_start && !entry_done;
	assign walk_open    = walk_status == STAT_WALKING || walk_status == STAT_CLEAN_END;

	`CNAW_ASSERT_NEXT(a_input_holds, in_stall, item_valid && $stable(in_word))

	`CNAW_ASSERT_NEXT(a_result_holds, out_stall, result_valid && $stable(out_word))

	`CNAW_ASSERT_NOW(a_start_on_header, start_word, byte_role == ROLE_HDR && !entry_done)

	`CNAW_ASSERT_NOW(a_ignored_after_stop, ignored_word, walk_status != STAT_WALKING && quiet_flags)

	`CNAW_ASSERT_NOW(a_done_not_stopped, done_word, walk_open)

endmodule

bind cpio_newc_archive_walker cnaw_checker u_cnaw_checker (.*);

@@ bench/cpio_newc_archive_walker_tb.sv @@
// ----------------------------------------------------------------------------
// cpio_newc_archive_walker_tb
// Self-checking bench for the newc archive walker. Archive entries are built
// byte by byte, streamed through the byte channel with random gaps, and every
// result word is compared field by field against an in-bench model of the walk.
// ----------------------------------------------------------------------------
// A walk ends for good on a bad magic, a TRAILER!!! name or the byte marked
// last, and reset is applied only once. So the run is one long archive: a
// directed table of entries, a few hundred bytes of random entries, and
// then one ending picked at random, followed by a few bytes that the walker
// must report as ignored.
module cpio_newc_archive_walker_tb
	import cnaw_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		role_t       role;
		logic        start;
		logic        done;
		logic [31:0] name_len;
		logic [31:0] file_len;
		status_t     status;
	} walk_word_t;

	// How the name bytes of a built entry are filled.
	typedef enum logic [1:0] {
		NAME_PLAIN,
		NAME_EXTREME,
		NAME_TRAILER,
		NAME_NEAR_TRAILER
	} name_kind_t;

	// How the eight hex digits of a size field are spelled.
	typedef enum logic [1:0] {
		DIGITS_UPPER,
		DIGITS_LOWER,
		DIGITS_JUNK,
		DIGITS_MIXED
	} digit_style_t;

	// The one way this run's walk comes to a stop.
	typedef enum logic [2:0] {
		END_BAD_MAGIC,
		END_TRAILER,
		END_CLEAN,
		END_MID_ENTRY,
		END_HUGE_SIZES
	} ending_t;

	typedef struct packed {
		logic [31:0]  ns;
		logic [31:0]  fs;
		name_kind_t   kind;
		digit_style_t style;
	} entry_row_t;

	localparam logic [7:0] MAGIC_TEXT [6] = '{"0", "7", "0", "7", "0", "1"};
	localparam logic [7:0] TRAILER_TEXT [10] =
		'{"T", "R", "A", "I", "L", "E", "R", "!", "!", "!"};

	// Regions longer than this are cut short when an entry is built; only the
	// ending with huge sizes ever reaches it, and it stops past the name size field.
	localparam int unsigned BUILD_CAP = 64;
	localparam int unsigned RANDOM_BYTES = 150;
	localparam int unsigned TAIL_BYTES = 16;

	// Directed entries. Together they cover an empty name and empty data,
	// an entry with no padding at all, a name that is a short prefix of the
	// trailer, names that miss the trailer by one byte, a name of alternating
	// all-zero and all-one bytes, every hex letter in one case or the other, and
	// non-hex characters standing for zero digits.
	localparam entry_row_t DIRECTED_ROWS [6] = '{
		'{32'd0,     32'd0,     NAME_PLAIN,        DIGITS_UPPER},
		'{32'd2,     32'h0000_000C, NAME_EXTREME,  DIGITS_LOWER},
		'{32'd9,     32'h0000_000D, NAME_TRAILER,  DIGITS_JUNK},
		'{32'd11,    32'h0000_003B, NAME_NEAR_TRAILER, DIGITS_MIXED},
		'{32'd10,    32'h0000_002A, NAME_NEAR_TRAILER, DIGITS_UPPER},
		'{32'h0000_000F, 32'h0000_001E, NAME_PLAIN, DIGITS_LOWER}
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        item_valid = 1'b0;
	logic        item_ready;
	logic [7:0]  image_byte = 8'd0;
	logic        image_last = 1'b0;
	logic        result_valid;
	logic        result_ready = 1'b0;
	logic [2:0]  byte_role;
	logic        entry_start;
	logic        entry_done;
	logic [31:0] name_length;
	logic [31:0] file_length;
	logic [2:0]  walk_status;

	// Model of the walk, advanced once per accepted byte word.
	role_t       walk_region;
	logic [31:0] walk_offset;
	logic [31:0] hex_acc;
	logic [31:0] name_len_q;
	logic [31:0] file_len_q;
	logic        trailer_ok;
	status_t     walk_stat;

	walk_word_t  expected_labels [$];
	logic [7:0]  entry_bytes [$];
	int unsigned bytes_sent = 0;
	int unsigned mismatch_count = 0;
	int unsigned tx_idle_pct = 0;
	int unsigned rx_idle_pct = 0;

	cpio_newc_archive_walker DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.image_byte   (image_byte),
		.image_last   (image_last),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.byte_role    (byte_role),
		.entry_start  (entry_start),
		.entry_done   (entry_done),
		.name_length  (name_length),
		.file_length  (file_length),
		.walk_status  (walk_status)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	initial begin
		#2_000_000;
		$display("cpio_newc_archive_walker test failed");
		$finish;
	end

	function automatic logic [3:0] digit_value(input logic [7:0] c);
		if (c >= "0" && c <= "9") begin
			return 4'(c - "0");
		end
		if (c >= "a" && c <= "f") begin
			return 4'(c - "a" + 8'd10);
		end
		if (c >= "A" && c <= "F") begin
			return 4'(c - "A" + 8'd10);
		end
		return 4'd0;
	endfunction

	// Length of a region of the current entry; the pads bring the name end and
	// the data end to a four-byte boundary counted from the entry start.
	function automatic logic [31:0] region_span(input role_t r);
		case (r)
			ROLE_HDR: begin
				return HDR_LEN;
			end
			ROLE_NAME: begin
				return name_len_q;
			end
			ROLE_NPAD: begin
				return (32'd0 - (HDR_LEN + name_len_q)) & 32'd3;
			end
			ROLE_DATA: begin
				return file_len_q;
			end
			default: begin
				return (32'd0 - file_len_q) & 32'd3;
			end
		endcase
	endfunction

	// Labels one byte and moves the walk on; returns the word the walker owes.
	function automatic walk_word_t label_byte(input logic [7:0] b, input logic mark);
		walk_word_t  w;
		logic [31:0] off;
		role_t       nxt;
		w.role = ROLE_IGN;
		w.start = 1'b0;
		w.done = 1'b0;
		if (walk_stat == STAT_WALKING) begin
			off = walk_offset;
			w.role = walk_region;
			if (walk_region == ROLE_HDR) begin
				if (off == 32'd0) begin
					w.start = 1'b1;
					trailer_ok = 1'b1;
				end
				if (off < MAGIC_LEN && b != MAGIC_TEXT[off]) begin
					walk_stat = STAT_BAD_MAGIC;
				end
				// Both size fields shift in one nibble per byte, restarting on
				// their first digit.
				if ((off >= FSIZE_FIRST && off <= FSIZE_LAST) ||
						(off >= NSIZE_FIRST && off <= NSIZE_LAST)) begin
					if (off == FSIZE_FIRST || off == NSIZE_FIRST) begin
						hex_acc = 32'(digit_value(b));
					end else begin
						hex_acc = (hex_acc << 4) | 32'(digit_value(b));
					end
					if (off == FSIZE_LAST) begin
						file_len_q = hex_acc;
					end
					if (off == NSIZE_LAST) begin
						name_len_q = hex_acc;
					end
				end
			end else if (walk_region == ROLE_NAME && off < TRAILER_LEN) begin
				if (b != TRAILER_TEXT[off]) begin
					trailer_ok = 1'b0;
				end
				if (off == TRAILER_LEN - 1 && trailer_ok && name_len_q >= TRAILER_LEN) begin
					walk_stat = STAT_TRAILER;
				end
			end
			if (walk_stat == STAT_WALKING) begin
				off = off + 32'd1;
				if (off >= region_span(walk_region)) begin
					// Skip every empty region; running past the data pad closes
					// the entry.
					nxt = walk_region + 3'd1;
					while (nxt <= ROLE_DPAD && region_span(nxt) == 32'd0) begin
						nxt = nxt + 3'd1;
					end
					if (nxt > ROLE_DPAD) begin
						nxt = ROLE_HDR;
						w.done = 1'b1;
					end
					walk_region = nxt;
					off = 32'd0;
				end
				walk_offset = off;
				if (mark) begin
					walk_stat = (walk_region == ROLE_HDR && walk_offset == 32'd0) ?
						STAT_CLEAN_END : STAT_MID_ENTRY;
				end
			end
		end
		w.name_len = name_len_q;
		w.file_len = file_len_q;
		w.status = walk_stat;
		return w;
	endfunction

	// Fills entry_bytes with one archive entry: magic, random header filler,
	// the two size fields in the given style, then name, and pads and data when both sizes fit the cap.
	task automatic build_entry(input logic [31:0] ns, input logic [31:0] fs,
			input name_kind_t kind, input digit_style_t style);
		logic [31:0] fld;
		logic [3:0]  nib;
		logic [7:0]  c;
		logic        upper;
		int unsigned idx;
		int unsigned nbuilt;
		int unsigned p;
		entry_bytes.delete();
		for (int i = 0; i < HDR_LEN; i++) begin
			if (i < MAGIC_LEN) begin
				c = MAGIC_TEXT[i];
			end else if ((i >= FSIZE_FIRST && i <= FSIZE_LAST) ||
					(i >= NSIZE_FIRST && i <= NSIZE_LAST)) begin
				fld = (i <= FSIZE_LAST) ? fs : ns;
				idx = (i <= FSIZE_LAST) ? i - FSIZE_FIRST : i - NSIZE_FIRST;
				nib = 4'(fld >> (28 - 4 * idx));
				upper = (style == DIGITS_UPPER) ||
					(style != DIGITS_LOWER && $urandom_range(0, 1) == 1);
				if (nib == 4'd0 && (style == DIGITS_JUNK ||
						(style == DIGITS_MIXED && $urandom_range(0, 2) == 0))) begin
					// Any character that is not a hex digit decodes as zero.
					do begin
						c = 8'($urandom_range(0, 255));
					end while (c == "0" || digit_value(c) != 4'd0);
				end else if (nib < 4'd10) begin
					c = "0" + 8'(nib);
				end else begin
					c = (upper ? "A" : "a") + 8'(nib) - 8'd10;
				end
			end else begin
				c = 8'($urandom_range(0, 255));
			end
			entry_bytes.push_back(c);
		end
		nbuilt = (ns > BUILD_CAP) ? BUILD_CAP : ns;
		for (int unsigned i = 0; i < nbuilt; i++) begin
			c = 8'($urandom_range(0, 255));
			if ((kind == NAME_TRAILER || kind == NAME_NEAR_TRAILER) && i < TRAILER_LEN) begin
				c = TRAILER_TEXT[i];
			end
			if (kind == NAME_EXTREME) begin
				c = i[0] ? 8'hFF : 8'h00;
			end
			entry_bytes.push_back(c);
		end
		if (kind == NAME_NEAR_TRAILER && nbuilt != 0) begin
			// Spoil exactly one of the trailer characters.
			p = $urandom_range(0, ((nbuilt < TRAILER_LEN) ? nbuilt : TRAILER_LEN) - 1);
			entry_bytes[HDR_LEN + p] = TRAILER_TEXT[p] ^ 8'($urandom_range(1, 255));
		end
		if (ns <= BUILD_CAP && fs <= BUILD_CAP) begin
			repeat ((32'd0 - (HDR_LEN + ns)) & 32'd3) begin
				entry_bytes.push_back(8'($urandom_range(0, 255)));
			end
			repeat (fs + ((32'd0 - fs) & 32'd3)) begin
				entry_bytes.push_back(8'($urandom_range(0, 255)));
			end
		end
	endtask

	// Offers one byte word, holding it steady until the walker takes it, and
	// queues the label the walker owes for it.
	task automatic put_byte(input logic [7:0] b, input logic mark);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		image_byte <= b;
		image_last <= mark;
		do begin
			@(posedge clk);
		end while (!item_ready);
		expected_labels.push_back(label_byte(b, mark));
		bytes_sent++;
	endtask

	// Sends entry_bytes up to and including index cut. Directed rows pin the
	// label of the last header byte to the typed-in lengths of the row.
	task automatic send_span(input int unsigned cut, input logic mark_last,
			input logic pin, input walk_word_t pin_word);
		for (int unsigned i = 0; i <= cut; i++) begin
			put_byte(entry_bytes[i], mark_last && i == cut);
			if (pin && i == HDR_LEN - 1) begin
				expected_labels[expected_labels.size() - 1] = pin_word;
			end
		end
	endtask

	// Stops offering bytes until the walker has returned every owed label.
	task automatic hold_until_drained();
		item_valid <= 1'b0;
		do begin
			@(posedge clk);
		end while (expected_labels.size() != 0);
	endtask

	task automatic set_idling(input int phase);
		tx_idle_pct = (phase == 0) ? 11 : (phase == 1) ? 83 : 0;
		rx_idle_pct = (phase == 0) ? 83 : (phase == 1) ? 11 : 0;
	endtask

	task automatic check_field(input string field, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %0h actual %0h", $time, field, want, got);
			mismatch_count++;
		end
	endtask

	// Result side: check every word taken, then pick the next ready at random.
	always @(posedge clk) begin : result_side
		walk_word_t want;
		if (arst_n && result_valid && result_ready) begin
			if (expected_labels.size() == 0) begin
				$display("%0t: unexpected result word, expected none, actual role %0d status %0d",
					$time, byte_role, walk_status);
				mismatch_count++;
			end else begin
				want = expected_labels.pop_front();
				check_field("byte_role", 32'(want.role), 32'(byte_role));
				check_field("entry_start", 32'(want.start), 32'(entry_start));
				check_field("entry_done", 32'(want.done), 32'(entry_done));
				check_field("name_length", want.name_len, name_length);
				check_field("file_length", want.file_len, file_length);
				check_field("walk_status", 32'(want.status), 32'(walk_status));
			end
		end
		result_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
	end

	initial begin
		entry_row_t   row;
		logic [31:0]  ns;
		logic [31:0]  fs;
		name_kind_t   kind;
		digit_style_t style;
		ending_t      ending;
		int unsigned  random_start;
		int unsigned  pick;
		int unsigned  k;

		walk_region = ROLE_HDR;
		walk_offset = 32'd0;
		hex_acc = 32'd0;
		name_len_q = 32'd0;
		file_len_q = 32'd0;
		trailer_ok = 1'b1;
		walk_stat = STAT_WALKING;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed entries, sent in the first idling phase.
		set_idling(0);
		for (int r = 0; r < $size(DIRECTED_ROWS); r++) begin
			row = DIRECTED_ROWS[r];
			build_entry(row.ns, row.fs, row.kind, row.style);
			send_span(entry_bytes.size() - 1, 1'b0, 1'b1,
				'{ROLE_HDR, 1'b0, 1'b0, row.ns, row.fs, STAT_WALKING});
		end

		// Random well-formed entries in the two remaining idling phases. At
		// each phase change the sender waits for every owed label first.
		for (int phase = 1; phase < 3; phase++) begin
			hold_until_drained();
			set_idling(phase);
			random_start = bytes_sent;
			while (bytes_sent - random_start < RANDOM_BYTES / 2) begin
				pick = $urandom_range(0, 9);
				if (pick == 0) begin
					kind = NAME_NEAR_TRAILER;
					ns = $urandom_range(1, 16);
				end else if (pick == 1) begin
					// Prefix of the trailer that is too short to count.
					kind = NAME_TRAILER;
					ns = $urandom_range(1, 9);
				end else begin
					kind = (pick == 2) ? NAME_EXTREME : NAME_PLAIN;
					ns = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 60) :
						$urandom_range(0, 16);
				end
				fs = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 60) :
					$urandom_range(0, 32);
				style = digit_style_t'($urandom_range(0, 3));
				build_entry(ns, fs, kind, style);
				send_span(entry_bytes.size() - 1, 1'b0, 1'b0, '0);
			end
		end

		// The walk stops exactly once, so one ending is picked per run.
		ending = ending_t'($urandom_range(0, 4));
		ns = $urandom_range(0, 16);
		fs = $urandom_range(0, 32);
		style = digit_style_t'($urandom_range(0, 3));
		case (ending)
			END_BAD_MAGIC: begin
				build_entry(ns, fs, NAME_PLAIN, style);
				k = $urandom_range(0, MAGIC_LEN - 1);
				entry_bytes[k] = MAGIC_TEXT[k] ^ 8'($urandom_range(1, 255));
				send_span(k, 1'b0, 1'b0, '0);
			end
			END_TRAILER: begin
				build_entry($urandom_range(10, 14), fs, NAME_TRAILER, style);
				send_span(entry_bytes.size() - 1, 1'b0, 1'b0, '0);
			end
			END_CLEAN: begin
				build_entry(ns, fs, NAME_PLAIN, style);
				send_span(entry_bytes.size() - 1, 1'b1, 1'b0, '0);
			end
			END_MID_ENTRY: begin
				build_entry(ns, fs, NAME_PLAIN, style);
				send_span($urandom_range(0, entry_bytes.size() - 2), 1'b1, 1'b0, '0);
			end
			default: begin
				// Both sizes all ones; the image ends past the name size field, in the header or the name.
				build_entry(32'hFFFF_FFFF, 32'hFFFF_FFFF, NAME_PLAIN, style);
				send_span($urandom_range(NSIZE_LAST + 1, entry_bytes.size() - 1),
					1'b1, 1'b0, '0);
			end
		endcase

		// After the stop every byte is ignored, whatever its last flag says.
		for (int unsigned i = 0; i < TAIL_BYTES; i++) begin
			put_byte(8'($urandom_range(0, 255)),
				i == TAIL_BYTES - 1 || $urandom_range(0, 3) == 0);
		end

		hold_until_drained();
		repeat (8) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("cpio_newc_archive_walker test passed");
		end else begin
			$display("cpio_newc_archive_walker test failed");
		end
		$finish;
	end

endmodule
